[rtl/core/pidt_pkg.sv]
// ----------------------------------------------------------------------------
// pidt_pkg
// shared widths, action codes and the result beat type of the protected id
// table
// ----------------------------------------------------------------------------
`default_nettype none

package pidt_pkg;

    localparam int DEFAULT_DEPTH = 256;

    localparam int ACTION_W = 3;
    localparam int PID_W    = 32;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 8;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_EXIT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    typedef struct packed {
        logic               ok;
        logic               is_protected;
        logic [COUNT_W-1:0] entry_count;
        logic [PID_W-1:0]   entry_value;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/pidt_in_if.sv]
// ----------------------------------------------------------------------------
// pidt_in_if
// request channel: one action beat with identifier and read index
// ----------------------------------------------------------------------------
`default_nettype none

interface pidt_in_if;

    logic                         valid;
    logic                         ready;
    logic [pidt_pkg::ACTION_W-1:0] action;
    logic [pidt_pkg::PID_W-1:0]    pid;
    logic [pidt_pkg::INDEX_W-1:0]  index;

    modport source (output valid, output action, output pid, output index, input ready);
    modport sink   (input valid, input action, input pid, input index, output ready);

endinterface

`default_nettype wire

[rtl/core/pidt_out_if.sv]
// ----------------------------------------------------------------------------
// pidt_out_if
// response channel: one result beat per request
// ----------------------------------------------------------------------------
`default_nettype none

interface pidt_out_if;

    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic                         is_protected;
    logic [pidt_pkg::COUNT_W-1:0] entry_count;
    logic [pidt_pkg::PID_W-1:0]   entry_value;

    modport source (output valid, output ok, output is_protected, output entry_count,
                    output entry_value, input ready);
    modport sink   (input valid, input ok, input is_protected, input entry_count,
                    input entry_value, output ready);

endinterface

`default_nettype wire

[rtl/core/protected_id_table_core.sv]
// ----------------------------------------------------------------------------
// protected_id_table_core
// unordered table of process identifiers with a live count
//
// req carries one action beat (add, remove, check, exit, read) with pid and
// index; rsp returns exactly one result beat per request, in order.
// a request is taken only when the sequencer is idle; one action is in
// flight at a time.
// remove and exit run a linear search that reads one entry per cycle
// through the single read port of the store; a hit past the front moves
// the last entry into the hole.
// the result sits in an output register, so a new request is taken while
// an earlier result still waits on a stalled receiver; a second result
// waits in the sequencer until the register frees.
// reset clears the live count and the flop copies of the two front entries
// at once; no clearing pass runs over the store, which holds nothing
// readable until written.
// ----------------------------------------------------------------------------
`default_nettype none

module protected_id_table_core #(
    parameter int TABLE_DEPTH = pidt_pkg::DEFAULT_DEPTH
) (
    input wire logic    clk,
    input wire logic    rst_n,
    pidt_in_if.sink     req,
    pidt_out_if.source  rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                       mem_ren;
    logic [AW-1:0]              mem_raddr;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [pidt_pkg::PID_W-1:0] mem_wdata;
    logic [pidt_pkg::PID_W-1:0] mem_rdata;

    logic                       res_valid;
    logic                       res_ready;
    pidt_pkg::res_t             res;

    logic                       out_valid_reg;
    pidt_pkg::res_t             out_reg;

    pidt_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    pidt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_ren   (mem_ren),
        .mem_raddr (mem_raddr),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_reg.ok;
    assign rsp.is_protected = out_reg.is_protected;
    assign rsp.entry_count  = out_reg.entry_count;
    assign rsp.entry_value  = out_reg.entry_value;

endmodule

`default_nettype wire

[rtl/core/pidt_mem.sv]
// ----------------------------------------------------------------------------
// pidt_mem
// identifier store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pidt_mem #(
    parameter int DEPTH = pidt_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      ren,
    input  wire logic [AW-1:0]             raddr,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [pidt_pkg::PID_W-1:0] wdata,
    output logic      [pidt_pkg::PID_W-1:0] rdata
);

    logic [pidt_pkg::PID_W-1:0] mem [DEPTH];
    logic [pidt_pkg::PID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/pidt_ctrl.sv]
// ----------------------------------------------------------------------------
// pidt_ctrl
// action sequencer: runs add, remove, check, exit and read against the store,
// keeps the live count and flop copies of the two front entries
// ----------------------------------------------------------------------------
`default_nettype none

module pidt_ctrl #(
    parameter int DEPTH = pidt_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    pidt_in_if.sink                         req,
    output logic                            mem_ren,
    output logic      [AW-1:0]              mem_raddr,
    output logic                            mem_we,
    output logic      [AW-1:0]              mem_waddr,
    output logic      [pidt_pkg::PID_W-1:0] mem_wdata,
    input  wire logic [pidt_pkg::PID_W-1:0] mem_rdata,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output pidt_pkg::res_t                  res
);

    localparam int CW = (AW > pidt_pkg::COUNT_W) ? AW : pidt_pkg::COUNT_W;
    localparam logic [AW-1:0] FULL = AW'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                    state_reg,  state_next;
    logic [AW-1:0]                 count_reg,  count_next;
    logic [pidt_pkg::PID_W-1:0]    front0_reg, front0_next;
    logic [pidt_pkg::PID_W-1:0]    front1_reg, front1_next;
    logic [AW-1:0]                 scan_reg,   scan_next;
    logic                          pend_reg,   pend_next;
    logic [AW-1:0]                 paddr_reg,  paddr_next;
    logic [AW-1:0]                 hit_reg,    hit_next;
    logic                          ok_reg,     ok_next;
    logic                          prot_reg,   prot_next;
    logic [pidt_pkg::PID_W-1:0]    value_reg,  value_next;

    logic [pidt_pkg::ACTION_W-1:0] act_reg;
    logic [pidt_pkg::PID_W-1:0]    pid_reg;
    logic [pidt_pkg::INDEX_W-1:0]  idx_reg;

    logic [AW-1:0] last;
    logic          prot_now;
    logic          idx_live;
    logic [CW-1:0] count_wide;

    assign last       = count_reg - AW'(1);
    assign prot_now   = (front0_reg == pid_reg) || (front1_reg == pid_reg);
    assign idx_live   = CW'(idx_reg) < CW'(count_reg);
    assign count_wide = CW'(count_reg);
    assign req.ready  = (state_reg == ST_IDLE);

    assign res.ok           = ok_reg;
    assign res.is_protected = prot_reg;
    assign res.entry_count  = count_wide[pidt_pkg::COUNT_W-1:0];
    assign res.entry_value  = value_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        front0_next = front0_reg;
        front1_next = front1_reg;
        scan_next   = scan_reg;
        pend_next   = pend_reg;
        paddr_next  = paddr_reg;
        hit_next    = hit_reg;
        ok_next     = ok_reg;
        prot_next   = prot_reg;
        value_next  = value_reg;
        mem_ren     = 1'b0;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        res_valid   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ok_next    = 1'b0;
                prot_next  = 1'b0;
                value_next = '0;
                state_next = ST_DONE;
                unique case (act_reg) inside
                    pidt_pkg::ACT_ADD:
                    begin
                        if (count_reg < FULL)
                        begin
                            ok_next = 1'b1;
                            if (pid_reg == '0)
                            begin
                                count_next = '0;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg;
                                mem_wdata  = pid_reg;
                                count_next = count_reg + AW'(1);
                                if (count_reg == AW'(0))
                                begin
                                    front0_next = pid_reg;
                                end
                                if (count_reg == AW'(1))
                                begin
                                    front1_next = pid_reg;
                                end
                            end
                        end
                    end
                    pidt_pkg::ACT_REMOVE, pidt_pkg::ACT_EXIT:
                    begin
                        if (act_reg == pidt_pkg::ACT_EXIT)
                        begin
                            prot_next = prot_now;
                        end
                        if ((act_reg == pidt_pkg::ACT_REMOVE || prot_now)
                            && count_reg != '0)
                        begin
                            state_next = ST_SEARCH;
                            scan_next  = '0;
                            pend_next  = 1'b0;
                        end
                    end
                    pidt_pkg::ACT_CHECK:
                    begin
                        prot_next = prot_now;
                    end
                    pidt_pkg::ACT_READ:
                    begin
                        if (idx_live)
                        begin
                            mem_ren    = 1'b1;
                            mem_raddr  = AW'(idx_reg);
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SEARCH:
            begin
                if (pend_reg && mem_rdata == pid_reg)
                begin
                    ok_next = 1'b1;
                    if (paddr_reg == '0)
                    begin
                        // match at the front clears the whole live range
                        count_next  = '0;
                        front0_next = '0;
                        if (count_reg != AW'(1))
                        begin
                            front1_next = '0;
                        end
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        mem_ren    = 1'b1;
                        mem_raddr  = last;
                        hit_next   = paddr_reg;
                        state_next = ST_FETCH;
                    end
                end
                else if (!pend_reg && scan_reg >= count_reg && scan_reg != '0)
                begin
                    state_next = ST_DONE;
                end
                else if (scan_reg < count_reg)
                begin
                    mem_ren    = 1'b1;
                    mem_raddr  = scan_reg;
                    paddr_next = scan_reg;
                    pend_next  = 1'b1;
                    scan_next  = scan_reg + AW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_FETCH:
            begin
                // last entry moves into the hole, last slot reads as zero
                mem_we     = 1'b1;
                mem_waddr  = hit_reg;
                mem_wdata  = mem_rdata;
                count_next = last;
                if (last == AW'(1))
                begin
                    front1_next = '0;
                end
                else if (hit_reg == AW'(1))
                begin
                    front1_next = mem_rdata;
                end
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                ok_next    = 1'b1;
                value_next = mem_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            front0_reg <= '0;
            front1_reg <= '0;
            scan_reg   <= '0;
            pend_reg   <= 1'b0;
            paddr_reg  <= '0;
            hit_reg    <= '0;
            ok_reg     <= 1'b0;
            prot_reg   <= 1'b0;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            front0_reg <= front0_next;
            front1_reg <= front1_next;
            scan_reg   <= scan_next;
            pend_reg   <= pend_next;
            paddr_reg  <= paddr_next;
            hit_reg    <= hit_next;
            ok_reg     <= ok_next;
            prot_reg   <= prot_next;
            value_reg  <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg <= req.action;
            pid_reg <= req.pid;
            idx_reg <= req.index;
        end
    end

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_EXEC || state_reg == ST_FETCH))
        else $error("store written outside add or move");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    a_fetch_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> ($past(state_reg) == ST_SEARCH))
        else $error("move without search hit");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == '0
            || count_reg == AW'($past(count_reg) + AW'(1))
            || count_reg == AW'($past(count_reg) - AW'(1))))
        else $error("live count jumped");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("live count above limit");

endmodule

`default_nettype wire

[bench/protected_id_table_core_tb.sv]
// ----------------------------------------------------------------------------
// protected_id_table_core_tb
// self-checking bench for the protected id table core. a short directed table
// of action beats runs first, with hand-typed results where they are obvious.
// random action beats follow, among them a run that fills the table. beats
// without a typed result are scored against a behavioural model. gaps are
// varied on both sides; one long receiver hold-off backs up the request side.
// ----------------------------------------------------------------------------
module protected_id_table_core_tb;

    import pidt_pkg::*;

    localparam int TABLE_DEPTH     = DEFAULT_DEPTH;
    localparam int TAIL_CYCLES     = TABLE_DEPTH + 16;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int GAP_HEAVY_PCT   = 78;
    localparam int GAP_LIGHT_PCT   = 14;

    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_e;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [PID_W-1:0]    p;
        logic [INDEX_W-1:0]  ix;
        bit                  typed;
        res_t                want;
    } step_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pidt_in_if  req ();
    pidt_out_if rsp ();

    protected_id_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [PID_W-1:0] id_model [TABLE_DEPTH];
    int               live_n;
    res_t             result_q [$];
    int               err_cnt        = 0;
    int               cycle_cnt      = 0;
    int               hold_off_asked = 0;
    gap_mode_e        gap_mode       = GAP_NONE;

    // adds, reads, checks, removes and exits, with stale entries, empty table and spare actions
    step_row_t steps [25] = '{
        '{ACT_READ,    32'h00000000, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0, 32'h0}},
        '{ACT_REMOVE,  32'h00000005, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0, 32'h0}},
        '{ACT_CHECK,   32'h00000000, 8'h00, 1'b1, '{1'b0, 1'b1, 8'd0, 32'h0}},
        '{ACT_EXIT,    32'h00000000, 8'h00, 1'b1, '{1'b0, 1'b1, 8'd0, 32'h0}},
        '{ACT_ADD,     32'hFFFFFFFF, 8'h00, 1'b1, '{1'b1, 1'b0, 8'd1, 32'h0}},
        '{ACT_ADD,     32'h00000001, 8'hFF, 1'b1, '{1'b1, 1'b0, 8'd2, 32'h0}},
        '{ACT_ADD,     32'hA5A5A5A5, 8'h00, 1'b1, '{1'b1, 1'b0, 8'd3, 32'h0}},
        '{ACT_ADD,     32'h5A5A5A5A, 8'h00, 1'b1, '{1'b1, 1'b0, 8'd4, 32'h0}},
        '{ACT_READ,    32'h00000000, 8'h03, 1'b0, '0},
        '{ACT_READ,    32'h00000000, 8'hFF, 1'b1, '{1'b0, 1'b0, 8'd4, 32'h0}},
        '{ACT_CHECK,   32'h00000001, 8'h00, 1'b1, '{1'b0, 1'b1, 8'd4, 32'h0}},
        '{ACT_CHECK,   32'h12345678, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd4, 32'h0}},
        '{ACT_REMOVE,  32'hA5A5A5A5, 8'h00, 1'b0, '0},
        '{ACT_READ,    32'h00000000, 8'h02, 1'b0, '0},
        '{ACT_EXIT,    32'h00000001, 8'h00, 1'b0, '0},
        '{ACT_ADD,     32'h00000000, 8'h00, 1'b1, '{1'b1, 1'b0, 8'd0, 32'h0}},
        '{ACT_CHECK,   32'hFFFFFFFF, 8'h00, 1'b1, '{1'b0, 1'b1, 8'd0, 32'h0}},
        '{ACT_EXIT,    32'hFFFFFFFF, 8'h00, 1'b1, '{1'b0, 1'b1, 8'd0, 32'h0}},
        '{ACT_ADD,     32'h00000077, 8'h00, 1'b0, '0},
        '{ACT_REMOVE,  32'h00000077, 8'h00, 1'b1, '{1'b1, 1'b0, 8'd0, 32'h0}},
        '{ACT_CHECK,   32'h5A5A5A5A, 8'h00, 1'b1, '{1'b0, 1'b1, 8'd0, 32'h0}},
        '{ACT_CHECK,   32'h00000000, 8'h00, 1'b1, '{1'b0, 1'b1, 8'd0, 32'h0}},
        '{ACT_SPARE_LO, 32'hFFFFFFFF, 8'hFF, 1'b1, '{1'b0, 1'b0, 8'd0, 32'h0}},
        '{ACT_SPARE_HI, 32'h00000000, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0, 32'h0}},
        '{ACT_EXIT,    32'hDEADBEEF, 8'h00, 1'b0, '0}
    };

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit stall_roll(bit heavy, bit light);
        if (heavy)
            return $urandom_range(99) < GAP_HEAVY_PCT;
        if (light)
            return $urandom_range(99) < GAP_LIGHT_PCT;
        return 1'b0;
    endfunction

    function automatic bit take_out_id(logic [PID_W-1:0] p);
        int last;
        if (live_n == 0)
            return 1'b0;
        for (int i = 0; i < live_n; i++)
        begin
            if (id_model[i] == p)
            begin
                if (i == 0)
                begin
                    for (int j = 0; j < live_n; j++)
                        id_model[j] = '0;
                    live_n = 0;
                end
                else
                begin
                    last           = live_n - 1;
                    id_model[i]    = id_model[last];
                    id_model[last] = '0;
                    live_n         = last;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic res_t apply_action(logic [ACTION_W-1:0] act, logic [PID_W-1:0] p,
                                          logic [INDEX_W-1:0] ix);
        res_t r;
        r = '0;
        case (act)
            ACT_ADD:
                if (live_n < TABLE_DEPTH - 1)
                begin
                    if (p == '0)
                        live_n = 0;
                    else
                    begin
                        id_model[live_n] = p;
                        live_n++;
                    end
                    r.ok = 1'b1;
                end
            ACT_REMOVE:
                r.ok = take_out_id(p);
            ACT_CHECK:
                r.is_protected = (id_model[0] == p) || (id_model[1] == p);
            ACT_EXIT:
            begin
                r.is_protected = (id_model[0] == p) || (id_model[1] == p);
                if (r.is_protected)
                    r.ok = take_out_id(p);
            end
            ACT_READ:
                if (int'(ix) < live_n)
                begin
                    r.ok          = 1'b1;
                    r.entry_value = id_model[ix];
                end
            default: ;
        endcase
        r.entry_count = COUNT_W'(live_n);
        return r;
    endfunction

    function automatic logic [PID_W-1:0] fresh_pid();
        logic [PID_W-1:0] p;
        // small ids now and then so that duplicates turn up
        p = ($urandom_range(99) < 15) ? PID_W'($urandom_range(4, 1)) : PID_W'($urandom);
        return (p == '0) ? PID_W'(1) : p;
    endfunction

    task automatic pick_request(output logic [ACTION_W-1:0] act, output logic [PID_W-1:0] p,
                                output logic [INDEX_W-1:0] ix);
        int roll;
        roll = $urandom_range(99);
        ix   = INDEX_W'($urandom_range(255));
        p    = fresh_pid();
        if (roll < 35)
            act = ACT_ADD;
        else if (roll < 38)
        begin
            act = ACT_ADD;
            p   = '0;
        end
        else if (roll < 58)
        begin
            act = ACT_REMOVE;
            if (live_n > 0 && roll < 55)
                p = id_model[$urandom_range(live_n - 1)];
        end
        else if (roll < 68)
        begin
            act = ACT_CHECK;
            if (roll < 65)
                p = id_model[$urandom_range(1)];
        end
        else if (roll < 80)
        begin
            act = ACT_EXIT;
            if (roll < 77)
                p = id_model[$urandom_range(1)];
        end
        else if (roll < 97)
        begin
            act = ACT_READ;
            if (live_n > 0 && roll < 93)
                ix = INDEX_W'($urandom_range(live_n - 1));
        end
        else
            act = ACTION_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    endtask

    task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [PID_W-1:0] p,
                             input logic [INDEX_W-1:0] ix, input bit typed = 1'b0,
                             input res_t typed_res = '0);
        res_t predicted;
        while (stall_roll(gap_mode == GAP_SENDER, gap_mode == GAP_BOTH))
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.action <= act;
        req.pid    <= p;
        req.index  <= ix;
        do
            @(posedge clk);
        while (!req.ready);
        predicted = apply_action(act, p, ix);
        result_q.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (result_q.size() != 0);
    endtask

    task automatic random_beats(input int n);
        logic [ACTION_W-1:0] act;
        logic [PID_W-1:0]    p;
        logic [INDEX_W-1:0]  ix;
        repeat (n)
        begin
            pick_request(act, p, ix);
            send_beat(act, p, ix);
        end
    endtask

    task automatic check_field(input string name, input logic [PID_W-1:0] want,
                               input logic [PID_W-1:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // response side
    initial
    begin
        int hold_off_seen;
        int hold_left;
        hold_off_seen = 0;
        hold_left     = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_asked != hold_off_seen)
            begin
                hold_off_seen = hold_off_asked;
                hold_left     = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= !stall_roll(gap_mode == GAP_RECEIVER, gap_mode == GAP_BOTH);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (result_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: result beat with nothing expected, ok %b prot %b count %0d value %h",
                         $time, rsp.ok, rsp.is_protected, rsp.entry_count, rsp.entry_value);
            end
            else
            begin
                want = result_q.pop_front();
                check_field("ok", want.ok, rsp.ok);
                check_field("is_protected", want.is_protected, rsp.is_protected);
                check_field("entry_count", want.entry_count, rsp.entry_count);
                check_field("entry_value", want.entry_value, rsp.entry_value);
            end
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            id_model[i] = '0;
        live_n = 0;
        req.valid  <= 1'b0;
        req.action <= ACT_ADD;
        req.pid    <= '0;
        req.index  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_mode = GAP_NONE;
        foreach (steps[k])
            send_beat(steps[k].act, steps[k].p, steps[k].ix, steps[k].typed, steps[k].want);

        gap_mode = GAP_SENDER;
        random_beats(70);
        gap_mode = GAP_RECEIVER;
        random_beats(70);
        drain_results();

        // fill the table behind a long receiver hold-off
        gap_mode = GAP_BOTH;
        hold_off_asked++;
        while (live_n < TABLE_DEPTH - 1)
            send_beat(ACT_ADD, fresh_pid(), INDEX_W'($urandom_range(255)));
        send_beat(ACT_ADD, fresh_pid(), '0);
        send_beat(ACT_ADD, '0, '0);
        send_beat(ACT_READ, '0, INDEX_W'(TABLE_DEPTH - 2));
        send_beat(ACT_READ, '1, '1);
        send_beat(ACT_REMOVE, id_model[TABLE_DEPTH - 2], '0);
        send_beat(ACT_REMOVE, id_model[live_n / 2], '0);
        send_beat(ACT_EXIT, id_model[0], '0);
        drain_results();

        gap_mode = GAP_NONE;
        random_beats(60);

        req.valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[protected_id_table_core.f]
rtl/core/pidt_pkg.sv
rtl/core/pidt_in_if.sv
rtl/core/pidt_out_if.sv
rtl/core/pidt_mem.sv
rtl/core/pidt_ctrl.sv
rtl/core/protected_id_table_core.sv
bench/protected_id_table_core_tb.sv
